>>> hw/rtl/fvad_pkg.sv
// Shared types and constants for the frame voice activity detector.
// Holds the register map, the state codes and the configuration bundle.
// Has no dependencies.
`default_nettype none

package fvad_pkg;

  localparam int unsigned NUM_REGS  = 7;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned LEVEL_W   = 18;
  localparam int unsigned PROD_W    = 24;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_FLOOR_OFFSET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVATE_OFFSET = 3'd1;
  localparam logic [IDX_W-1:0] REG_HOLD_MARGIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZCR_LIMIT       = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_MS        = 3'd4;
  localparam logic [IDX_W-1:0] REG_VOICE_HOLD_MS   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SILENCE_HOLD_MS = 3'd6;

  // State codes as seen on the output.
  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_QUIET    = 3'd1;
  localparam logic [2:0] MODE_ONSET    = 3'd2;
  localparam logic [2:0] MODE_SPEECH   = 3'd3;
  localparam logic [2:0] MODE_HANGOVER = 3'd4;

  typedef struct packed {
    logic signed [15:0] floor_offset;
    logic signed [15:0] activate_offset;
    logic signed [15:0] hold_margin;
    logic [15:0]        zcr_limit;
    logic [7:0]         frame_ms;
    logic [15:0]        voice_hold_ms;
    logic [15:0]        silence_hold_ms;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/fvad_cfg_regs.sv
// Configuration register file of the voice activity detector.
// Depends on fvad_pkg for the register map and the cfg_t bundle.
`default_nettype none

module fvad_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fvad_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [fvad_pkg::DATA_W-1:0] cfg_data,
  output fvad_pkg::cfg_t                 cfg
);
  import fvad_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_offset    <= 16'sd1280;
      cfg.activate_offset <= 16'sd1280;
      cfg.hold_margin     <= 16'sd512;
      cfg.zcr_limit       <= 16'd0;
      cfg.frame_ms        <= 8'd10;
      cfg.voice_hold_ms   <= 16'd50;
      cfg.silence_hold_ms <= 16'd100;
    end else if (cfg_we) begin
      // Writes to an index beyond the map are dropped.
      unique case (cfg_index)
        REG_FLOOR_OFFSET:    cfg.floor_offset    <= cfg_data;
        REG_ACTIVATE_OFFSET: cfg.activate_offset <= cfg_data;
        REG_HOLD_MARGIN:     cfg.hold_margin     <= cfg_data;
        REG_ZCR_LIMIT:       cfg.zcr_limit       <= cfg_data;
        REG_FRAME_MS:        cfg.frame_ms        <= cfg_data[7:0];
        REG_VOICE_HOLD_MS:   cfg.voice_hold_ms   <= cfg_data;
        REG_SILENCE_HOLD_MS: cfg.silence_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fvad_fsm.sv
// Detector state machine: mode, frame counter and noise floor, plus the
// threshold and hold-time decisions. Depends on fvad_pkg.
`default_nettype none

module fvad_fsm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic signed [15:0] power,
  input  wire logic [15:0]        zcr,
  input  wire fvad_pkg::cfg_t     cfg,
  output logic [2:0]              mode_next,
  output logic                    voice_next
);
  import fvad_pkg::*;

  typedef enum logic [2:0] {
    S_INIT          = MODE_INIT,
    S_SILENCE       = MODE_QUIET,
    S_MAYBE_VOICE   = MODE_ONSET,
    S_VOICE         = MODE_SPEECH,
    S_MAYBE_SILENCE = MODE_HANGOVER
  } mode_t;

  mode_t              mode;
  logic [15:0]        frame_count;
  logic signed [15:0] noise_floor;

  mode_t                     mode_sel;
  logic [15:0]               frame_count_next;
  logic signed [15:0]        noise_floor_next;
  logic signed [16:0]        floor_sum;
  logic signed [LEVEL_W-1:0] act_level;
  logic signed [LEVEL_W-1:0] hold_level;
  logic signed [LEVEL_W-1:0] power_ext;
  logic                      zcr_hit;
  logic                      active;
  logic                      keep;
  logic [15:0]               count_inc;
  logic [PROD_W-1:0]         hold_time;

  always_comb begin
    floor_sum  = {power[15], power} + {cfg.floor_offset[15], cfg.floor_offset};
    act_level  = {{2{noise_floor[15]}}, noise_floor}
               + {{2{cfg.activate_offset[15]}}, cfg.activate_offset};
    hold_level = act_level - {{2{cfg.hold_margin[15]}}, cfg.hold_margin};
    power_ext  = {{2{power[15]}}, power};
    zcr_hit    = (cfg.zcr_limit != 16'd0) && (zcr > cfg.zcr_limit);
    active     = (power_ext > act_level) || zcr_hit;
    keep       = (power_ext > hold_level) || zcr_hit;
    count_inc  = (frame_count == 16'hFFFF) ? frame_count : frame_count + 16'd1;
    hold_time  = PROD_W'(count_inc) * PROD_W'(cfg.frame_ms);

    mode_sel         = mode;
    frame_count_next = frame_count;
    noise_floor_next = noise_floor;

    unique case (mode)
      S_INIT: begin
        // The first frame sets the floor, saturated to the 16-bit range.
        if (floor_sum[16] != floor_sum[15]) begin
          noise_floor_next = floor_sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
          noise_floor_next = floor_sum[15:0];
        end
        mode_sel = S_SILENCE;
      end
      S_SILENCE: begin
        if (active) begin
          mode_sel         = S_MAYBE_VOICE;
          frame_count_next = 16'd1;
        end
      end
      S_MAYBE_VOICE: begin
        if (keep) begin
          frame_count_next = count_inc;
          if (hold_time >= PROD_W'(cfg.voice_hold_ms)) mode_sel = S_VOICE;
        end else begin
          mode_sel = S_SILENCE;
        end
      end
      S_VOICE: begin
        if (!keep) begin
          mode_sel         = S_MAYBE_SILENCE;
          frame_count_next = 16'd1;
        end
      end
      S_MAYBE_SILENCE: begin
        if (!keep) begin
          frame_count_next = count_inc;
          if (hold_time >= PROD_W'(cfg.silence_hold_ms)) mode_sel = S_SILENCE;
        end else begin
          mode_sel = S_VOICE;
        end
      end
      default: ;
    endcase

    mode_next  = mode_sel;
    voice_next = (mode_sel == S_VOICE) || (mode_sel == S_MAYBE_SILENCE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= S_INIT;
      frame_count <= 16'd0;
      noise_floor <= 16'sd0;
    end else if (step) begin
      mode        <= mode_sel;
      frame_count <= frame_count_next;
      noise_floor <= noise_floor_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/frame_voice_activity_fsm_unit.sv
// Top level of the frame voice activity detector: input register, state
// machine, result register. Depends on fvad_pkg, fvad_cfg_regs, fvad_fsm.
`default_nettype none

// One word per audio frame (power in dB Q7.8 and zero-crossing rate) goes
// into an input register; once the result register is free the state machine
// updates its mode, frame counter and noise floor and the decision lands in
// the result register. A new word is taken every cycle while the result side
// keeps draining; the state update of the single FSM stage is the only loop.
// Configuration writes take effect on the next edge and belong between
// frames, while the block is idle.
module frame_voice_activity_fsm_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [fvad_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [fvad_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [15:0]          frame_power,
  input  wire logic [15:0]                 frame_zcr,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             is_voice,
  output logic [2:0]                       fsm_state
);
  import fvad_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic signed [15:0] s1_power;
  logic [15:0]        s1_zcr;
  logic               out_free;
  logic               s1_advance;
  logic [2:0]         mode_next;
  logic               voice_next;

  fvad_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fvad_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_advance),
    .power      (s1_power),
    .zcr        (s1_zcr),
    .cfg        (cfg),
    .mode_next  (mode_next),
    .voice_next (voice_next)
  );

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_power <= frame_power;
      s1_zcr   <= frame_zcr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      is_voice  <= voice_next;
      fsm_state <= mode_next;
    end
  end

  // The voice flag must agree with the reported state.
  a_voice_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_voice == ((fsm_state == MODE_SPEECH) ||
                                (fsm_state == MODE_HANGOVER))))
    else $error("is_voice disagrees with fsm_state");

  a_state_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fsm_state <= MODE_HANGOVER))
    else $error("fsm_state holds an unreachable code");

  // A word waiting in the input register must not vanish while stalled.
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("stalled input word lost");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word not captured");

endmodule

`default_nettype wire
